FILE: src/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and helpers for the second-difference packer.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned BlockLen  = 20;
  localparam int unsigned GroupLen  = 4;
  localparam int unsigned NumGroups = BlockLen / GroupLen;
  localparam int unsigned BufBits   = 96;
  localparam int unsigned WordBits  = 64;

  typedef logic [1:0] section_t;
  localparam section_t SEC_FIRST = 2'd0;
  localparam section_t SEC_INDEX = 2'd1;
  localparam section_t SEC_DATA  = 2'd2;
  localparam section_t SEC_ERROR = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input beat
    logic calc;     // take differences, update frame state
    logic index;    // emit index word, open packing
    logic append;   // pack next value into the bit buffer
    logic chunk;    // emit up to 8 bytes from the bit buffer
    logic last;     // chunk is the final result of the run
  } ssd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a result
    logic block_full;  // this sample completes a block
    logic fill_ge64;   // buffer holds a whole word
    logic fill_eq64;   // buffer holds exactly one word
    logic all_in;      // all block values packed
  } ssd_status_t;

  // Group width from the OR of ones'-complement magnitudes
  function automatic logic [5:0] group_width(input logic [31:0] acc);
    logic [5:0] w;
    if      ((acc & 32'h7800_0000) != 32'd0) w = 6'd32;
    else if ((acc & 32'h0780_0000) != 32'd0) w = 6'd28;
    else if ((acc & 32'h0078_0000) != 32'd0) w = 6'd24;
    else if ((acc & 32'h0006_0000) != 32'd0) w = 6'd20;
    else if ((acc & 32'h0001_8000) != 32'd0) w = 6'd18;
    else if ((acc & 32'h0000_6000) != 32'd0) w = 6'd16;
    else if ((acc & 32'h0000_1800) != 32'd0) w = 6'd14;
    else if ((acc & 32'h0000_0600) != 32'd0) w = 6'd12;
    else if ((acc & 32'h0000_0180) != 32'd0) w = 6'd10;
    else if ((acc & 32'h0000_0060) != 32'd0) w = 6'd8;
    else if ((acc & 32'h0000_0018) != 32'd0) w = 6'd6;
    else                                     w = 6'd4;
    return w;
  endfunction

endpackage

FILE: src/ssd_if.sv
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channels carrying input samples and packed results.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface ssd_out_if;
  logic              valid;
  logic              ready;
  ssd_pkg::section_t section;
  logic [63:0]       payload;
  logic [3:0]        byte_count;
  logic              end_of_frame;
  logic              last_of_run;
  modport source (output valid, section, payload, byte_count, end_of_frame, last_of_run,
                  input ready);
  modport sink   (input valid, section, payload, byte_count, end_of_frame, last_of_run,
                  output ready);
endinterface

FILE: src/ssd_ctrl.sv
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer: accept, difference, then index and packing for a full block.
// ----------------------------------------------------------------------------
module ssd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssd_pkg::ssd_status_t status,
  output ssd_pkg::ssd_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_INDEX = 4'b0100,
    S_PACK  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        if (status.out_free) begin
          cmd.calc   = 1'b1;
          state_next = status.block_full ? S_INDEX : S_IDLE;
        end
      end
      S_INDEX: begin
        if (status.out_free) begin
          cmd.index  = 1'b1;
          state_next = S_PACK;
        end
      end
      S_PACK: begin
        priority if (status.fill_ge64) begin
          if (status.out_free) begin
            cmd.chunk = 1'b1;
            cmd.last  = status.all_in && status.fill_eq64;
            if (cmd.last) state_next = S_IDLE;
          end
        end else if (!status.all_in) begin
          cmd.append = 1'b1;
        end else if (status.out_free) begin
          cmd.chunk  = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          // hold until the output register frees
          state_next = state;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/ssd_datapath.sv
// ----------------------------------------------------------------------------
// ssd_datapath
// Difference registers, block shift line, group widths, bit packer, output.
// ----------------------------------------------------------------------------
module ssd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_kind,
  input  logic [31:0]          in_sample,
  input  ssd_pkg::ssd_cmd_t    cmd,
  output ssd_pkg::ssd_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssd_pkg::section_t    out_section,
  output logic [63:0]          out_payload,
  output logic [3:0]           out_byte_count,
  output logic                 out_eof,
  output logic                 out_last
);

  logic        kind;
  logic [31:0] sample;
  logic [31:0] prev;
  logic [31:0] pfd;
  logic        started;
  logic        have;
  logic [4:0]  pos;
  logic [31:0] acc;
  logic        wide;
  logic [5:0]  widths [ssd_pkg::NumGroups];
  logic [31:0] diffs  [ssd_pkg::BlockLen];
  logic [4:0]  cnt;
  logic [6:0]  fill;
  logic [ssd_pkg::BufBits-1:0] bits;

  logic [31:0] d1, d2, mag, acc_n;
  logic [5:0]  gw;
  logic [5:0]  rw [ssd_pkg::NumGroups];
  logic [15:0] idx;
  logic [31:0] val_l;
  logic [ssd_pkg::BufBits-1:0] placed;
  logic        out_free;
  logic        out_load;

  assign d1    = sample - prev;
  assign d2    = have ? d1 - pfd : d1;
  assign mag   = d2[31] ? ~d2 : d2;
  assign acc_n = ((pos[1:0] == 2'd0) ? 32'd0 : acc) | mag;
  assign gw    = ssd_pkg::group_width(acc_n);

  always_comb begin
    for (int g = 0; g < ssd_pkg::NumGroups; g++) begin
      rw[g] = wide ? widths[g] + {4'b0000, widths[g][1], 1'b0} : widths[g];
    end
    if (wide) begin
      idx = 16'h8000 | ({10'd0, rw[0] - 6'd4} << 10) | ({10'd0, rw[1] - 6'd4} << 7)
          | ({10'd0, rw[2] - 6'd4} << 4) | ({10'd0, rw[3] - 6'd4} << 1)
          | ({10'd0, rw[4] - 6'd4} >> 2);
    end else begin
      idx = ({10'd0, rw[0] - 6'd4} << 11) | ({10'd0, rw[1] - 6'd4} << 8)
          | ({10'd0, rw[2] - 6'd4} << 5) | ({10'd0, rw[3] - 6'd4} << 2)
          | ({10'd0, rw[4] - 6'd4} >> 1);
    end
  end

  // Left-align the value so bit w-1 lands at the top, then drop it behind the fill
  assign val_l  = diffs[0] << (6'd32 - rw[0]);
  assign placed = {val_l, {ssd_pkg::WordBits{1'b0}}} >> fill;

  assign out_free          = !out_valid || out_ready;
  assign out_load          = cmd.index || cmd.chunk ||
                             (cmd.calc && (!started || (kind && (pos != 5'd19))));
  assign status.out_free   = out_free;
  assign status.block_full = started && (pos == 5'd19);
  assign status.fill_ge64  = fill >= 7'd64;
  assign status.fill_eq64  = fill == 7'd64;
  assign status.all_in     = cnt == 5'(ssd_pkg::BlockLen);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= in_kind;
      sample <= in_sample;
    end
    if (cmd.calc && started) begin
      diffs[ssd_pkg::BlockLen-1] <= d2;
      for (int i = 0; i < ssd_pkg::BlockLen - 1; i++) diffs[i] <= diffs[i+1];
      acc <= acc_n;
      if (pos[1:0] == 2'd3) begin
        widths[ssd_pkg::NumGroups-1] <= gw;
        for (int g = 0; g < ssd_pkg::NumGroups - 1; g++) widths[g] <= widths[g+1];
        wide <= ((pos < 5'd4) ? 1'b0 : wide) | (gw > 6'd18);
      end
    end
    if (cmd.index) begin
      bits <= '0;
    end else if (cmd.append) begin
      bits <= bits | placed;
      for (int i = 0; i < ssd_pkg::BlockLen - 1; i++) diffs[i] <= diffs[i+1];
      if (cnt[1:0] == 2'd3) begin
        widths[ssd_pkg::NumGroups-1] <= widths[0];
        for (int g = 0; g < ssd_pkg::NumGroups - 1; g++) widths[g] <= widths[g+1];
      end
    end else if (cmd.chunk) begin
      bits <= bits << ssd_pkg::WordBits;
    end
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      pfd       <= '0;
      started   <= 1'b0;
      have      <= 1'b0;
      pos       <= '0;
      cnt       <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.calc) begin
        if (!started) begin
          out_last     <= 1'b1;
          out_eof      <= kind;
          if (kind) begin
            out_section    <= ssd_pkg::SEC_ERROR;
            out_payload    <= '0;
            out_byte_count <= 4'd0;
          end else begin
            out_section    <= ssd_pkg::SEC_FIRST;
            out_payload    <= {sample, 32'd0};
            out_byte_count <= 4'd4;
            prev           <= sample;
            started        <= 1'b1;
          end
        end else if (kind) begin
          prev    <= '0;
          pfd     <= '0;
          started <= 1'b0;
          have    <= 1'b0;
          pos     <= '0;
          if (pos != 5'd19) begin
            out_section    <= ssd_pkg::SEC_ERROR;
            out_payload    <= '0;
            out_byte_count <= 4'd0;
            out_eof        <= 1'b1;
            out_last       <= 1'b1;
          end
        end else begin
          pfd  <= d1;
          have <= 1'b1;
          prev <= sample;
          pos  <= (pos == 5'd19) ? 5'd0 : pos + 5'd1;
        end
      end
      if (cmd.index) begin
        cnt            <= '0;
        fill           <= '0;
        out_section    <= ssd_pkg::SEC_INDEX;
        out_payload    <= {idx, 48'd0};
        out_byte_count <= 4'd2;
        out_eof        <= 1'b0;
        out_last       <= 1'b0;
      end
      if (cmd.append) begin
        cnt  <= cnt + 5'd1;
        fill <= fill + {1'b0, rw[0]};
      end
      if (cmd.chunk) begin
        out_section    <= ssd_pkg::SEC_DATA;
        out_payload    <= bits[ssd_pkg::BufBits-1 -: ssd_pkg::WordBits];
        out_byte_count <= (fill >= 7'd64) ? 4'd8 : fill[6:3];
        out_eof        <= cmd.last && kind;
        out_last       <= cmd.last;
        fill           <= (fill >= 7'd64) ? fill - 7'd64 : 7'd0;
      end
    end
  end

endmodule

FILE: src/seismic_second_difference_packer_top.sv
// ----------------------------------------------------------------------------
// seismic_second_difference_packer_top
// Second-difference packer for framed 32-bit seismic samples.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  in_ch   | in  | kind (0 sample, 1 closing value), sample
//  out_ch  | out | section, payload, byte_count, end_of_frame, last_of_run
//
//  Each input beat is accepted in idle; its differences are then formed in the
//  difference registers once the output is free. A beat that completes a block
//  of 20 then emits the index word and packs the values one per cycle through
//  the bit buffer, interleaved with a chunk of up to 8 bytes whenever the buffer
//  holds a whole word and the output is free; a last chunk ends the block.
//  Reset (rst, synchronous) clears the frame state; the block shift line holds
//  no reset. A stalled output holds the difference step and every result step.
module seismic_second_difference_packer_top (
  input logic clk,
  input logic rst,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch
);

  ssd_pkg::ssd_cmd_t    cmd;
  ssd_pkg::ssd_status_t status;

  // Sequencer: hold in idle for a beat, advance through the block emission
  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath owns the output register so a result waits there while work goes on
  ssd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_kind        (in_ch.kind),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_section    (out_ch.section),
    .out_payload    (out_ch.payload),
    .out_byte_count (out_ch.byte_count),
    .out_eof        (out_ch.end_of_frame),
    .out_last       (out_ch.last_of_run)
  );

endmodule
